[design/expiring_slot_allocator_top_defines.svh]
// ----------------------------------------------------------------------------
// expiring slot allocator assertion macros
// Shared assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXPIRING_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define EXPIRING_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define ESA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("esa assertion failed");
// checked on every edge, reset included
`define ESA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("esa assertion failed");
`else
`define ESA_ASSERT(lbl, prop)
`define ESA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[design/esa_pkg.sv]
// ----------------------------------------------------------------------------
// esa_pkg
// Types and constants shared by the expiring slot allocator modules.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_W      = 16;

  localparam logic [15:0] DURATION_RST = 16'd500;
  localparam logic [23:0] COLOR_RST    = 24'hFFFFFF;
  localparam logic [3:0]  EXP_SAT      = 4'hF;
  localparam logic [3:0]  EXP_LIMIT    = (NUM_SLOTS > 15) ? 4'hF : 4'(NUM_SLOTS);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SPAWN = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_FIND,
    S_WRITE,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic tick_step;
    logic find_step;
    logic spawn_write;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic out_free;
  } dp_status_t;

endpackage

[design/esa_ctrl.sv]
// ----------------------------------------------------------------------------
// esa_ctrl
// Sequencer: takes one item, walks the slot table for ticks and spawns, then loads the result.
// ----------------------------------------------------------------------------
`include "expiring_slot_allocator_top_defines.svh"

module esa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_req_i,
  output logic                in_ready_o,
  input  esa_pkg::dp_status_t status_i,
  output esa_pkg::dp_cmd_t    cmd_o
);
  import esa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_e'(in_req_i))
            REQ_TICK:  state_d = S_TICK;
            REQ_SPAWN: state_d = S_FIND;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      S_TICK: begin
        if (status_i.last_slot) state_d = S_EMIT;
      end
      S_FIND: begin
        if (status_i.last_slot) state_d = S_WRITE;
      end
      S_WRITE: state_d = S_EMIT;
      S_EMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        // ready is always high here, so valid alone marks the accepting edge
        cmd_o.capture = in_valid_i;
      end
      S_TICK:  cmd_o.tick_step   = 1'b1;
      S_FIND:  cmd_o.find_step   = 1'b1;
      S_WRITE: cmd_o.spawn_write = 1'b1;
      S_EMIT:  cmd_o.emit        = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  `ESA_ASSERT(a_accept_leaves_idle, accept |=> state_q != S_IDLE)
  `ESA_ASSERT(a_one_cmd_at_a_time, $onehot0(cmd_o))

endmodule

[design/esa_dp.sv]
// ----------------------------------------------------------------------------
// esa_dp
// Slot table, scan registers, duration register and result register.
// ----------------------------------------------------------------------------
`include "expiring_slot_allocator_top_defines.svh"

module esa_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  esa_pkg::dp_cmd_t                      cmd_i,
  output esa_pkg::dp_status_t                   status_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [esa_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic [esa_pkg::IN_DATA_W-1:0]         in_data_i,
  input  logic [1:0]                            in_user_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [esa_pkg::OUT_DATA_W-1:0]        out_data_o
);
  import esa_pkg::*;

  // configuration
  logic [15:0] duration_q;

  // captured item
  logic [1:0]  req_q;
  logic [15:0] elapsed_q;
  logic [15:0] cx_q;
  logic [15:0] cy_q;
  logic [9:0]  radius_q;
  logic [23:0] color_q;
  logic [2:0]  rd_slot_q;

  // scan state
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  logic [IDX_W-1:0] free_sel_q;
  logic [IDX_W-1:0] min_sel_q;
  logic [15:0]      best_q;
  logic [3:0]       exp_cnt_q;

  // table
  logic        act_q    [NUM_SLOTS];
  logic [15:0] rem_q    [NUM_SLOTS];
  logic [15:0] ex_cx_q  [NUM_SLOTS];
  logic [15:0] ex_cy_q  [NUM_SLOTS];
  logic [9:0]  ex_rad_q [NUM_SLOTS];
  logic [23:0] ex_col_q [NUM_SLOTS];

  // result register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_q;
  logic [OUT_DATA_W-1:0] res_d;

  logic             rd_act;
  logic [15:0]      rd_rem;
  logic [IDX_W-1:0] wr_slot;
  logic [6:0]       rs_ext;
  logic [6:0]       idx_ext;
  logic [6:0]       wr_ext;
  logic             rs_ok;
  logic             out_free;

  assign rd_act  = act_q[idx_q];
  assign rd_rem  = rem_q[idx_q];
  assign wr_slot = found_q ? free_sel_q : min_sel_q;
  assign rs_ext  = 7'(in_data_i[84:82]);
  assign idx_ext = 7'(idx_q);
  assign wr_ext  = 7'(wr_slot);
  assign rs_ok   = (7'(rd_slot_q) < 7'(NUM_SLOTS));
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.last_slot = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign status_o.out_free  = out_free;
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= DURATION_RST;
    end else if (cfg_valid_i) begin
      duration_q <= cfg_data_i;
    end
  end

  // item capture, payload and request type
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= in_user_i;
      elapsed_q <= in_data_i[15:0];
      cx_q      <= in_data_i[31:16];
      cy_q      <= in_data_i[47:32];
      radius_q  <= in_data_i[57:48];
      color_q   <= {in_data_i[65:58], in_data_i[73:66], in_data_i[81:74]};
      rd_slot_q <= in_data_i[84:82];
    end
  end

  // scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      found_q    <= 1'b0;
      free_sel_q <= '0;
      min_sel_q  <= '0;
      best_q     <= '1;
      exp_cnt_q  <= '0;
    end else if (cmd_i.capture) begin
      idx_q      <= (req_e'(in_user_i) == REQ_READ) ? rs_ext[IDX_W-1:0] : '0;
      found_q    <= 1'b0;
      free_sel_q <= '0;
      min_sel_q  <= '0;
      best_q     <= '1;
      exp_cnt_q  <= '0;
    end else if (cmd_i.tick_step) begin
      idx_q <= idx_q + 1'b1;
      if (rd_act && (rd_rem <= elapsed_q) && (exp_cnt_q != EXP_SAT)) begin
        exp_cnt_q <= exp_cnt_q + 4'd1;
      end
    end else if (cmd_i.find_step) begin
      idx_q <= idx_q + 1'b1;
      // first free slot wins; strict compare keeps the lowest index on ties
      if (!found_q && !rd_act) begin
        found_q    <= 1'b1;
        free_sel_q <= idx_q;
      end
      if (rd_rem < best_q) begin
        best_q    <= rd_rem;
        min_sel_q <= idx_q;
      end
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        act_q[i]    <= 1'b0;
        rem_q[i]    <= '0;
        ex_cx_q[i]  <= '0;
        ex_cy_q[i]  <= '0;
        ex_rad_q[i] <= '0;
        ex_col_q[i] <= COLOR_RST;
      end
    end else if (cmd_i.tick_step) begin
      if (rd_act) begin
        if (rd_rem <= elapsed_q) begin
          rem_q[idx_q] <= '0;
          act_q[idx_q] <= 1'b0;
        end else begin
          rem_q[idx_q] <= rd_rem - elapsed_q;
        end
      end
    end else if (cmd_i.spawn_write) begin
      act_q[wr_slot]    <= 1'b1;
      rem_q[wr_slot]    <= duration_q;
      ex_cx_q[wr_slot]  <= cx_q;
      ex_cy_q[wr_slot]  <= cy_q;
      ex_rad_q[wr_slot] <= radius_q;
      ex_col_q[wr_slot] <= color_q;
    end
  end

  // result fields, lowest bit first: slot, replaced, active, cx, cy, radius,
  // red, green, blue, remaining, expired count
  always_comb begin
    res_d = '0;
    case (req_e'(req_q))
      REQ_TICK: begin
        res_d[90:87] = exp_cnt_q;
      end
      REQ_SPAWN: begin
        res_d = {5'd0, 4'd0, duration_q, color_q[7:0], color_q[15:8],
                 color_q[23:16], radius_q, cy_q, cx_q, 1'b1, !found_q,
                 wr_ext[2:0]};
      end
      REQ_READ: begin
        if (rs_ok) begin
          res_d = {5'd0, 4'd0, rd_rem, ex_col_q[idx_q][7:0],
                   ex_col_q[idx_q][15:8], ex_col_q[idx_q][23:16],
                   ex_rad_q[idx_q], ex_cy_q[idx_q], ex_cx_q[idx_q], rd_act,
                   1'b0, idx_ext[2:0]};
        end else begin
          res_d[2:0] = rd_slot_q;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_d;
    end
  end

  `ESA_ASSERT(a_emit_sets_valid, cmd_i.emit |=> out_valid_q)
  `ESA_ASSERT(a_spawn_marks_active, cmd_i.spawn_write |=> act_q[wr_slot])
  `ESA_ASSERT_ALWAYS(a_expired_bounded, !rst_ni || (exp_cnt_q <= EXP_LIMIT))

endmodule

[design/expiring_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// expiring_slot_allocator_top
// accept to result valid: a tick runs the tick scan over all slots, a spawn
//   the find scan and then the table write, a read goes straight to emit;
//   emit waits while the result register stays full. A new item is taken
//   only once the last result is loaded; scans visit one slot per cycle.
// reset: async active low; table cleared, colors white, duration 500 ms
// ----------------------------------------------------------------------------
module expiring_slot_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: effect_duration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [esa_pkg::CFG_W-1:0]         cfg_data_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // elapsed, center_x, center_y, radius, red, green, blue, read_slot
  input  logic [esa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type
  input  logic [1:0]                        s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_slot, out_replaced, out_active, out_center_x, out_center_y,
  // out_radius, out_red, out_green, out_blue, out_remaining, out_expired_count
  output logic [esa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import esa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  esa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
